FILE: src/drbb_pkg.sv
// Shared types and codes for the draw region bounding box unit.
// No dependencies.
package drbb_pkg;

   localparam int unsigned CoordWidth = 16;
   localparam int unsigned BoundWidth = 18;

   typedef enum logic [2:0] {
      CMD_POINT   = 3'd0,
      CMD_SEGMENT = 3'd1,
      CMD_SPAN    = 3'd2,
      CMD_RECT    = 3'd3,
      CMD_ARC     = 3'd4
   } cmd_type;

   typedef logic signed [BoundWidth-1:0] bound_type;

   // One registered primitive, already reduced to its extents.
   typedef struct packed {
      logic      has_prim;
      logic      last;
      cmd_type   kind;
      bound_type lo_x;
      bound_type hi_x;
      bound_type lo_y;
      bound_type hi_y;
   } prim_type;

endpackage

FILE: src/drbb_extent.sv
// Input register stage: turns one primitive into its x and y extents.
// Depends on drbb_pkg.
module drbb_extent (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_command,
   input  logic signed [15:0]   req_x,
   input  logic signed [15:0]   req_y,
   input  logic signed [15:0]   req_x_end,
   input  logic signed [15:0]   req_y_end,
   input  logic [15:0]          req_extent_w,
   input  logic [15:0]          req_extent_h,
   input  logic                 req_no_shape,
   input  logic                 req_last,
   input  logic                 take,
   output logic                 prim_valid,
   output drbb_pkg::prim_type   prim
);
   import drbb_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   prim_type  prim_ff;
   prim_type  prim_in;
   bound_type x0, y0, xe, ye, w, h;
   logic      load;

   assign req_ready  = !valid_ff || take;
   assign load       = req_valid && req_ready;
   assign prim_valid = valid_ff;
   assign prim       = prim_ff;

   always_comb begin
      x0 = {{(BoundWidth-CoordWidth){req_x[15]}}, req_x};
      y0 = {{(BoundWidth-CoordWidth){req_y[15]}}, req_y};
      xe = {{(BoundWidth-CoordWidth){req_x_end[15]}}, req_x_end};
      ye = {{(BoundWidth-CoordWidth){req_y_end[15]}}, req_y_end};
      w  = {{(BoundWidth-CoordWidth){1'b0}}, req_extent_w};
      h  = {{(BoundWidth-CoordWidth){1'b0}}, req_extent_h};

      prim_in.last     = req_last;
      prim_in.kind     = cmd_type'(req_command);
      prim_in.has_prim = !req_no_shape;
      prim_in.lo_x     = x0;
      prim_in.hi_x     = x0;
      prim_in.lo_y     = y0;
      prim_in.hi_y     = y0;
      unique case (prim_in.kind)
         CMD_POINT: begin
         end
         CMD_SEGMENT: begin
            prim_in.lo_x = (x0 < xe) ? x0 : xe;
            prim_in.hi_x = (x0 < xe) ? xe : x0;
            prim_in.lo_y = (y0 < ye) ? y0 : ye;
            prim_in.hi_y = (y0 < ye) ? ye : y0;
         end
         CMD_SPAN: begin
            prim_in.hi_x = x0 + w;
         end
         CMD_RECT, CMD_ARC: begin
            prim_in.hi_x = x0 + w;
            prim_in.hi_y = y0 + h;
         end
         default: begin
            // Unknown commands carry no primitive but still pick the size rule.
            prim_in.has_prim = 1'b0;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prim_ff <= prim_in;
      end
   end

endmodule

FILE: src/drbb_accum.sv
// Running bounds accumulator and result register.
// Depends on drbb_pkg; fed by drbb_extent.
module drbb_accum (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 prim_valid,
   input  drbb_pkg::prim_type   prim,
   output logic                 take,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [15:0]   rsp_rect_x,
   output logic signed [15:0]   rsp_rect_y,
   output logic [15:0]          rsp_rect_width,
   output logic [15:0]          rsp_rect_height
);
   import drbb_pkg::*;

   bound_type lo_x_ff, hi_x_ff, lo_y_ff, hi_y_ff;
   bound_type lo_x_in, hi_x_in, lo_y_in, hi_y_in;
   bound_type mlo_x, mhi_x, mlo_y, mhi_y;
   logic      any_seen_ff, any_seen_in, m_any;
   logic      rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rect_x_ff, rect_y_ff, rect_x_in, rect_y_in;
   logic [15:0] width_ff, height_ff, width_in, height_in;
   logic      emit;

   function automatic logic [15:0] size_of(input bound_type lo, input bound_type hi,
                                           input cmd_type kind);
      logic signed [BoundWidth:0] d;
      logic signed [BoundWidth:0] d_adj;
      logic [15:0]                 res;
      d = {hi[BoundWidth-1], hi} - {lo[BoundWidth-1], lo};
      unique case (kind)
         CMD_RECT: d_adj = (d <= 0) ? d + $signed({{BoundWidth{1'b0}}, 1'b1}) : d;
         CMD_ARC:  d_adj = d;
         default:  d_adj = d + $signed({{BoundWidth{1'b0}}, 1'b1});
      endcase
      if (d_adj < 0) begin
         res = 16'd0;
      end else if (d_adj > $signed({{(BoundWidth-15){1'b0}}, 16'hFFFF})) begin
         res = 16'hFFFF;
      end else begin
         res = d_adj[15:0];
      end
      return res;
   endfunction

   // A list end may only advance when the result register is free or draining.
   assign take = prim_valid && (!prim.last || !rsp_valid_ff || rsp_ready);
   assign emit = take && prim.last;

   always_comb begin
      mlo_x = lo_x_ff;
      mhi_x = hi_x_ff;
      mlo_y = lo_y_ff;
      mhi_y = hi_y_ff;
      m_any = any_seen_ff;
      if (prim.has_prim) begin
         m_any = 1'b1;
         if (!any_seen_ff) begin
            mlo_x = prim.lo_x;
            mhi_x = prim.hi_x;
            mlo_y = prim.lo_y;
            mhi_y = prim.hi_y;
         end else begin
            mlo_x = (prim.lo_x < lo_x_ff) ? prim.lo_x : lo_x_ff;
            mhi_x = (prim.hi_x > hi_x_ff) ? prim.hi_x : hi_x_ff;
            mlo_y = (prim.lo_y < lo_y_ff) ? prim.lo_y : lo_y_ff;
            mhi_y = (prim.hi_y > hi_y_ff) ? prim.hi_y : hi_y_ff;
         end
      end

      lo_x_in     = lo_x_ff;
      hi_x_in     = hi_x_ff;
      lo_y_in     = lo_y_ff;
      hi_y_in     = hi_y_ff;
      any_seen_in = any_seen_ff;
      if (emit) begin
         lo_x_in     = '0;
         hi_x_in     = '0;
         lo_y_in     = '0;
         hi_y_in     = '0;
         any_seen_in = 1'b0;
      end else if (take) begin
         lo_x_in     = mlo_x;
         hi_x_in     = mhi_x;
         lo_y_in     = mlo_y;
         hi_y_in     = mhi_y;
         any_seen_in = m_any;
      end

      // An empty list reports an all-zero rectangle.
      if (m_any) begin
         rect_x_in = mlo_x[15:0];
         rect_y_in = mlo_y[15:0];
         width_in  = size_of(mlo_x, mhi_x, prim.kind);
         height_in = size_of(mlo_y, mhi_y, prim.kind);
      end else begin
         rect_x_in = '0;
         rect_y_in = '0;
         width_in  = '0;
         height_in = '0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_x_ff      <= '0;
         hi_x_ff      <= '0;
         lo_y_ff      <= '0;
         hi_y_ff      <= '0;
         any_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lo_x_ff      <= lo_x_in;
         hi_x_ff      <= hi_x_in;
         lo_y_ff      <= lo_y_in;
         hi_y_ff      <= hi_y_in;
         any_seen_ff  <= any_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rect_x_ff <= rect_x_in;
         rect_y_ff <= rect_y_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rect_x      = rect_x_ff;
   assign rsp_rect_y      = rect_y_ff;
   assign rsp_rect_width  = width_ff;
   assign rsp_rect_height = height_ff;

   // A pending result is never overwritten before it is taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !emit)
      else $error("result overwritten while stalled");

   // A list end leaves a result and a cleared accumulator.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff && !any_seen_ff && lo_x_ff == '0 && hi_y_ff == '0)
      else $error("accumulator not cleared after list end");

   // With no primitive taken the bounds stay at their reset value.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      !any_seen_ff |-> lo_x_ff == '0 && hi_x_ff == '0 && lo_y_ff == '0 && hi_y_ff == '0)
      else $error("bounds changed without a primitive");

   // Bounds stay ordered once a primitive has been seen.
   a_ordered: assert property (@(posedge clock) disable iff (reset)
      any_seen_ff |-> lo_x_ff <= hi_x_ff && lo_y_ff <= hi_y_ff)
      else $error("bounds out of order");

endmodule

FILE: src/draw_region_bounding_box_unit.sv
// Draw region bounding box unit: running bounds of a primitive list.
// The last item of a list is registered in drbb_extent; its result is then registered in drbb_accum.
// Throughput: one item per cycle while no list end stalls; the min/max update of the four bounds sets that figure.
// A list end stalls only while the previous result is still held and not taken.
// Reset (synchronous, active high) empties the pipeline and clears the bounds.
module draw_region_bounding_box_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_command,
   input  logic signed [15:0]   req_x,
   input  logic signed [15:0]   req_y,
   input  logic signed [15:0]   req_x_end,
   input  logic signed [15:0]   req_y_end,
   input  logic [15:0]          req_extent_w,
   input  logic [15:0]          req_extent_h,
   input  logic                 req_no_shape,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [15:0]   rsp_rect_x,
   output logic signed [15:0]   rsp_rect_y,
   output logic [15:0]          rsp_rect_width,
   output logic [15:0]          rsp_rect_height
);
   import drbb_pkg::*;

   logic     take;
   logic     prim_valid;
   prim_type prim;

   drbb_extent u_extent (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_x        (req_x),
      .req_y        (req_y),
      .req_x_end    (req_x_end),
      .req_y_end    (req_y_end),
      .req_extent_w (req_extent_w),
      .req_extent_h (req_extent_h),
      .req_no_shape (req_no_shape),
      .req_last     (req_last),
      .take         (take),
      .prim_valid   (prim_valid),
      .prim         (prim)
   );

   drbb_accum u_accum (
      .clock           (clock),
      .reset           (reset),
      .prim_valid      (prim_valid),
      .prim            (prim),
      .take            (take),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rect_x      (rsp_rect_x),
      .rsp_rect_y      (rsp_rect_y),
      .rsp_rect_width  (rsp_rect_width),
      .rsp_rect_height (rsp_rect_height)
   );

endmodule

FILE: tb/sv/draw_region_bounding_box_unit_tb.sv
// Self-checking testbench for draw_region_bounding_box_unit: directed and random primitive
// lists are checked against a running bounding box predictor kept in a scoreboard class.
// Depends on drbb_pkg and the draw_region_bounding_box_unit RTL only.
module draw_region_bounding_box_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import drbb_pkg::*;

   localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] CMD_RESERVED_MID   = 3'd6;
   localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;
   localparam int unsigned IdleLimit = 5000;
   localparam int HoldCycles = 300;
   localparam int MaxReports = 40;

   class bbox_scoreboard;
      typedef struct {
         logic signed [15:0] x;
         logic signed [15:0] y;
         logic [15:0]        w;
         logic [15:0]        h;
      } box_type;

      bound_type low_x = '0;
      bound_type low_y = '0;
      bound_type high_x = '0;
      bound_type high_y = '0;
      bit any_shape = 1'b0;
      box_type pending_boxes[$];
      int errors = 0;
      int boxes_checked = 0;

      function void widen(bound_type x0, bound_type x1, bound_type y0, bound_type y1);
         if (!any_shape) begin
            low_x = x0;
            high_x = x1;
            low_y = y0;
            high_y = y1;
            any_shape = 1'b1;
            return;
         end
         if (x0 < low_x) low_x = x0;
         if (x1 > high_x) high_x = x1;
         if (y0 < low_y) low_y = y0;
         if (y1 > high_y) high_y = y1;
      endfunction

      // The command of the closing item picks the size rule, even without a primitive.
      function logic [15:0] box_size(bound_type lo, bound_type hi, logic [2:0] kind);
         int d;
         d = int'(hi) - int'(lo);
         if (kind == CMD_RECT) begin
            if (d <= 0) d++;
         end else if (kind != CMD_ARC) begin
            d++;
         end
         if (d < 0) d = 0;
         if (d > 65535) d = 65535;
         return d[15:0];
      endfunction

      function void take_primitive(logic [2:0] cmd, logic signed [15:0] x, y, xe, ye,
                                   logic [15:0] w, h, logic no_shape, last);
         bound_type bx, by, bxe, bye, bw, bh;
         box_type box;
         bx = x;
         by = y;
         bxe = xe;
         bye = ye;
         bw = {2'b00, w};
         bh = {2'b00, h};
         if (!no_shape) begin
            case (cmd)
               CMD_POINT: widen(bx, bx, by, by);
               CMD_SEGMENT: widen(bx < bxe ? bx : bxe, bx < bxe ? bxe : bx,
                                  by < bye ? by : bye, by < bye ? bye : by);
               CMD_SPAN: widen(bx, bx + bw, by, by);
               CMD_RECT, CMD_ARC: widen(bx, bx + bw, by, by + bh);
               default: ;
            endcase
         end
         if (last) begin
            if (any_shape) begin
               box.x = low_x[15:0];
               box.y = low_y[15:0];
               box.w = box_size(low_x, high_x, cmd);
               box.h = box_size(low_y, high_y, cmd);
            end else begin
               box = '{default: '0};
            end
            pending_boxes.push_back(box);
            low_x = '0;
            low_y = '0;
            high_x = '0;
            high_y = '0;
            any_shape = 1'b0;
         end
      endfunction

      function void mismatch(string field, int expected, int actual);
         errors++;
         if (errors <= MaxReports)
            $error("%s: expected %0d, got %0d", field, expected, actual);
      endfunction

      function void check_box(logic signed [15:0] x, y, logic [15:0] w, h);
         box_type box;
         if (pending_boxes.size() == 0) begin
            errors++;
            if (errors <= MaxReports)
               $error("unexpected rectangle: x %0d y %0d width %0d height %0d", x, y, w, h);
            return;
         end
         box = pending_boxes.pop_front();
         if (x !== box.x) mismatch("rect_x", int'(box.x), int'(x));
         if (y !== box.y) mismatch("rect_y", int'(box.y), int'(y));
         if (w !== box.w) mismatch("rect_width", int'(box.w), int'(w));
         if (h !== box.h) mismatch("rect_height", int'(box.h), int'(h));
         boxes_checked++;
      endfunction

      function int outstanding();
         return pending_boxes.size();
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_command = CMD_POINT;
   logic signed [15:0] req_x = '0;
   logic signed [15:0] req_y = '0;
   logic signed [15:0] req_x_end = '0;
   logic signed [15:0] req_y_end = '0;
   logic [15:0] req_extent_w = '0;
   logic [15:0] req_extent_h = '0;
   logic req_no_shape = 1'b0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_rect_x;
   logic signed [15:0] rsp_rect_y;
   logic [15:0] rsp_rect_width;
   logic [15:0] rsp_rect_height;

   bbox_scoreboard board = new();
   int items_sent = 0;
   int shapes_sent = 0;
   int lists_sent = 0;
   int boxes_seen = 0;
   bit hold_done = 1'b0;
   int unsigned idle_cycles = 0;

   draw_region_bounding_box_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_x           (req_x),
      .req_y           (req_y),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_extent_w    (req_extent_w),
      .req_extent_h    (req_extent_h),
      .req_no_shape    (req_no_shape),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rect_x      (rsp_rect_x),
      .rsp_rect_y      (rsp_rect_y),
      .rsp_rect_width  (rsp_rect_width),
      .rsp_rect_height (rsp_rect_height)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Valid stays high between back-to-back items; it only drops when a gap is drawn.
   task automatic send_item(input logic [2:0] cmd, input logic signed [15:0] x, y, xe, ye,
                            input logic [15:0] w, h, input logic no_shape, last);
      int gap;
      gap = (((items_sent / 120) % 4) == 2) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_x <= x;
      req_y <= y;
      req_x_end <= xe;
      req_y_end <= ye;
      req_extent_w <= w;
      req_extent_h <= h;
      req_no_shape <= no_shape;
      req_last <= last;
      do @(posedge clock); while (!req_ready);
      board.take_primitive(cmd, x, y, xe, ye, w, h, no_shape, last);
      items_sent++;
      if (last) lists_sent++;
      if ((!no_shape && cmd <= CMD_ARC) || last) shapes_sent++;
   endtask

   function automatic logic signed [15:0] random_coord(logic signed [15:0] center);
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return center + 16'($urandom_range(0, 64)) - 16'sd32;
   endfunction

   function automatic logic [15:0] random_extent();
      case ($urandom_range(0, 9))
         0: return '0;
         1, 2: return 16'($urandom);
         default: return 16'($urandom_range(0, 64));
      endcase
   endfunction

   // Mostly short lists around a random center; some long lists, some items
   // without a primitive and some reserved commands mixed in.
   task automatic send_random_list();
      int n;
      logic signed [15:0] cx, cy;
      logic [2:0] cmd;
      logic no_shape;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
      cx = 16'($urandom);
      cy = 16'($urandom);
      if ($urandom_range(0, 19) == 0) begin
         // Empty list: nothing but items without a primitive.
         for (int i = 0; i < n; i++)
            send_item(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom), 1'b1, i == n - 1);
         return;
      end
      for (int i = 0; i < n; i++) begin
         cmd = ($urandom_range(0, 11) == 0) ?
               3'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST)) :
               3'($urandom_range(CMD_POINT, CMD_ARC));
         no_shape = ($urandom_range(0, 9) == 0);
         send_item(cmd, random_coord(cx), random_coord(cy), random_coord(cx), random_coord(cy),
                   random_extent(), random_extent(), no_shape, i == n - 1);
      end
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (reset) @(posedge clock);

      // Empty lists, one with a reserved command and all-ones payload.
      send_item(CMD_POINT, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1);
      send_item(CMD_RESERVED_LAST, -1, -1, -1, -1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
      // Single primitives at the coordinate extremes, including saturation.
      send_item(CMD_POINT, -32768, 32767, 0, 0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
      send_item(CMD_SEGMENT, 32767, -32768, -32768, 32767, 0, 0, 1'b0, 1'b1);
      send_item(CMD_SPAN, -32768, 0, 0, 0, 16'hFFFF, 0, 1'b0, 1'b1);
      send_item(CMD_RECT, 5, 5, 0, 0, 0, 0, 1'b0, 1'b1);
      send_item(CMD_ARC, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1);
      send_item(CMD_RECT, 32767, 32767, 0, 0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
      send_item(CMD_ARC, -32768, -32768, 0, 0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
      // A reserved command closing the list falls back to the point rule.
      send_item(CMD_POINT, 10, 20, 0, 0, 0, 0, 1'b0, 1'b0);
      send_item(CMD_SEGMENT, -5, 30, 40, -7, 0, 0, 1'b0, 1'b0);
      send_item(CMD_RESERVED_FIRST, 1000, 1000, 1000, 1000, 50, 50, 1'b0, 1'b1);
      // A closing item without a primitive still selects the size rule.
      send_item(CMD_RECT, 0, 0, 0, 0, 10, 10, 1'b0, 1'b0);
      send_item(CMD_ARC, 99, 99, 99, 99, 99, 99, 1'b1, 1'b1);
      send_item(CMD_POINT, 3, 3, 0, 0, 0, 0, 1'b0, 1'b0);
      send_item(CMD_RECT, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1);
      // A reserved command alone adds nothing, so the list is empty.
      send_item(CMD_RESERVED_MID, 7, 7, 7, 7, 7, 7, 1'b0, 1'b1);
      send_item(CMD_ARC, 100, 100, 0, 0, 3, 4, 1'b0, 1'b0);
      send_item(CMD_SPAN, 50, 200, 0, 0, 20, 0, 1'b0, 1'b1);

      while (items_sent < 1050) send_random_list();
      req_valid <= 1'b0;

      while (board.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d items (%0d with a primitive or closing a list) in %0d lists.",
               items_sent, shapes_sent, lists_sent);
      $display("%0d rectangles compared; the receiver held off for %0d cycles once; %0d errors.",
               board.boxes_checked, HoldCycles, board.errors);
      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : receiver
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = (((boxes_seen / 30) % 4) == 2) ? 0 : $urandom_range(0, 3);
         // One long hold-off so the result buffer fills and the input stalls.
         if (boxes_seen == 25 && !hold_done) begin
            hold_done = 1'b1;
            gap = HoldCycles;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         board.check_box(rsp_rect_x, rsp_rect_y, rsp_rect_width, rsp_rect_height);
         boxes_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Timeout after %0d cycles without an accepted item.", idle_cycles);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
